/* src/mma_pkg.sv */
// ----------------------------------------------------------------------------
// Moving-average package
// Field widths and the shared divider status type of the multichannel moving-average core.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    // Fixed field widths.
    localparam int SUM_W     = 32;
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_IN_W = 3;
    localparam int LEN_IN_W  = 8;
    localparam int AVG_W     = 16;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

/* src/multichannel_moving_average_core.sv */
// ----------------------------------------------------------------------------
// Multichannel moving-average core
// Per-channel sample ring and running sum, averaged by a shared divider.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------
//  in       | i_in_valid / o_in_ready   | i_channel, i_sample, i_window_length
//  out      | o_out_valid / i_out_ready | o_average
//
// An item passes from its beat through one ring read, one update step, a
// setup step and 32 steps of the bit-serial divider, one step to see the
// divider finish, and one load of the output register; an item with an
// out-of-range channel skips the divider and yields zero. The next beat is
// taken only after that load, so one item is worked on at a time.
// The result waits in the output register, so the next beat is taken while
// it is stalled; a second result waits for the first to leave.
// The ring needs no clearing pass: a per-channel fill mark tells which slots
// were written since reset, and unwritten slots read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_moving_average_core #(
    parameter int CHANNELS     = 8,
    parameter int WINDOW_DEPTH = 128
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [mma_pkg::CHAN_IN_W-1:0] i_channel,
    input  wire logic signed [mma_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic        [mma_pkg::LEN_IN_W-1:0]  i_window_length,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed      [mma_pkg::AVG_W-1:0]     o_average
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W  = $clog2(WINDOW_DEPTH);
    localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W = $clog2(CHANNELS * WINDOW_DEPTH);
    localparam int RING_N = CHANNELS * WINDOW_DEPTH;
    localparam int SUM_W  = mma_pkg::SUM_W;
    localparam int SMP_W  = mma_pkg::SAMPLE_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]              r_state, n_state;

    // Per-channel state.
    logic [SUM_W-1:0]        r_sum  [CHANNELS];
    logic [POS_W-1:0]        r_pos  [CHANNELS];
    logic [LEN_W-1:0]        r_hwm  [CHANNELS];
    logic [CHANNELS-1:0]     r_full;

    // Sample ring.
    logic [SMP_W-1:0]        r_ring [RING_N];
    logic [SMP_W-1:0]        r_rd_data;
    logic [ADDR_W-1:0]       r_addr;

    // Item being worked on.
    logic                    r_ch_ok;
    logic [CH_W-1:0]         r_ch_idx;
    logic [SMP_W-1:0]        r_sample;
    logic [LEN_W-1:0]        r_len;

    // Output register.
    logic                    r_out_valid;
    logic [mma_pkg::AVG_W-1:0] r_average;

    logic                    in_beat;
    logic                    out_load;
    logic                    ch_ok_in;
    logic [31:0]             len_ext;
    logic [LEN_W-1:0]        len_in;
    logic [ADDR_W-1:0]       rd_addr;

    logic [SUM_W-1:0]        cur_sum;
    logic [POS_W-1:0]        cur_pos;
    logic [LEN_W-1:0]        cur_hwm;
    logic                    cur_full;
    logic [SMP_W-1:0]        old_smp;
    logic [SMP_W:0]          delta;
    logic [SUM_W-1:0]        new_sum;
    logic [LEN_W-1:0]        count;
    logic [LEN_W-1:0]        divisor;
    logic                    wrap;
    logic                    div_start;

    logic [mma_pkg::AVG_W-1:0] div_quotient;
    mma_pkg::t_div_status      div_status;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Window length with zero taken as one and long values saturated.
    always_comb begin
        ch_ok_in = (32'(i_channel) < CHANNELS);
        len_ext  = 32'(i_window_length);
        if (len_ext == 32'd0) begin
            len_ext = 32'd1;
        end
        if (len_ext > 32'(WINDOW_DEPTH)) begin
            len_ext = 32'(WINDOW_DEPTH);
        end
        len_in = LEN_W'(len_ext);
    end

    // Ring address of the channel's current slot.
    assign rd_addr = ADDR_W'(32'(r_ch_idx) * WINDOW_DEPTH + 32'(r_pos[r_ch_idx]));

    // Update arithmetic: add the new sample, drop the overwritten one once full.
    always_comb begin
        cur_sum  = r_sum[r_ch_idx];
        cur_pos  = r_pos[r_ch_idx];
        cur_hwm  = r_hwm[r_ch_idx];
        cur_full = r_full[r_ch_idx];
        old_smp  = (LEN_W'(cur_pos) < cur_hwm) ? r_rd_data : '0;
        if (cur_full) begin
            delta = {r_sample[SMP_W-1], r_sample} - {old_smp[SMP_W-1], old_smp};
        end else begin
            delta = {r_sample[SMP_W-1], r_sample};
        end
        new_sum   = cur_sum + {{(SUM_W-SMP_W-1){delta[SMP_W]}}, delta};
        count     = LEN_W'(cur_pos) + LEN_W'(1);
        divisor   = cur_full ? r_len : count;
        wrap      = (count >= r_len);
        div_start = (r_state == S_UPDATE) && r_ch_ok;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = r_ch_ok ? S_DIV : S_DONE;
            S_DIV: begin
                if (div_status.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item on its beat.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_ch_ok  <= ch_ok_in;
            r_ch_idx <= ch_ok_in ? CH_W'(32'(i_channel)) : '0;
            r_sample <= i_sample;
            r_len    <= len_in;
        end
    end

    // Ring read and write, both at the slot of the current item.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= r_ring[rd_addr];
            r_addr    <= rd_addr;
        end
        if ((r_state == S_UPDATE) && r_ch_ok) begin
            r_ring[r_addr] <= r_sample;
        end
    end

    // Per-channel sum, position, fill mark and full flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_pos[i] <= '0;
                r_hwm[i] <= '0;
            end
            r_full <= '0;
        end else if ((r_state == S_UPDATE) && r_ch_ok) begin
            r_sum[r_ch_idx]  <= new_sum;
            r_pos[r_ch_idx]  <= wrap ? '0 : POS_W'(count);
            r_hwm[r_ch_idx]  <= (count > cur_hwm) ? count : cur_hwm;
            r_full[r_ch_idx] <= cur_full | wrap;
        end
    end

    // Shared divider.
    mma_divider #(
        .DIV_W (LEN_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (new_sum),
        .i_divisor  (divisor),
        .o_quotient (div_quotient),
        .o_status   (div_status)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_average <= r_ch_ok ? div_quotient : '0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;

`ifndef SYNTH
    // A beat starts work, so the next cycle takes no beat.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_in_ready)
        else $error("input taken while an item is in work");

    // The divider runs only while the sequencer waits on it.
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_status.busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    // A loaded result shows up as valid.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

/* src/mma_divider.sv */
// ----------------------------------------------------------------------------
// Moving-average divider
// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_divider #(
    parameter int DIV_W = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [mma_pkg::SUM_W-1:0]    i_dividend,
    input  wire logic [DIV_W-1:0]             i_divisor,
    output logic      [mma_pkg::AVG_W-1:0]    o_quotient,
    output mma_pkg::t_div_status              o_status
);

    localparam int CNT_W = $clog2(mma_pkg::SUM_W);

    logic                        r_busy;
    logic                        r_prep;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [DIV_W-1:0]            r_rem;
    logic [mma_pkg::SUM_W-1:0]   r_quo;
    logic [DIV_W-1:0]            r_div;
    logic                        r_neg;

    logic [DIV_W:0]              rem_sh;
    logic [DIV_W:0]              trial;
    logic                        fit;
    logic [mma_pkg::AVG_W-1:0]   quo_low;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh = {r_rem, r_quo[mma_pkg::SUM_W-1]};
        trial  = rem_sh - {1'b0, r_div};
        fit    = ~trial[DIV_W];
    end

    // Control: a setup cycle takes the magnitude, then one step per bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_prep <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_prep <= 1'b1;
                r_cnt  <= '0;
            end else if (r_prep) begin
                r_prep <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(mma_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits shift in where the dividend bits leave.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_neg <= i_dividend[mma_pkg::SUM_W-1];
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_prep) begin
            if (r_neg) begin
                r_quo <= ~r_quo + mma_pkg::SUM_W'(1);
            end
        end else if (r_busy) begin
            r_quo <= {r_quo[mma_pkg::SUM_W-2:0], fit};
            r_rem <= fit ? trial[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
    end

    // Low bits of the quotient, sign restored.
    always_comb begin
        quo_low    = r_quo[mma_pkg::AVG_W-1:0];
        o_quotient = r_neg ? (~quo_low + mma_pkg::AVG_W'(1)) : quo_low;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

`default_nettype wire
